/* src/lafc_pkg.sv */
package lafc_pkg;

  typedef enum logic [1:0] {
    CMD_RX_PACKET  = 2'd0,
    CMD_RX_RELEASE = 2'd1,
    CMD_TX_QUEUE   = 2'd2,
    CMD_RESET      = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_CRC_ERROR = 3'd1,
    STATUS_RX_FULL   = 3'd2,
    STATUS_RX_EMPTY  = 3'd3,
    STATUS_TX_FULL   = 3'd4
  } status_t;

  localparam int SLOT_W  = 3;
  localparam int COUNT_W = 8;

  typedef struct packed {
    command_t command;
    logic     crc_ok;
    logic     hdr_sn;
    logic     hdr_nesn;
    logic     hdr_md;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  tx_slot;
    logic               tx_nesn;
    logic               tx_sn;
    logic               tx_md;
    logic               rx_accepted;
    logic [SLOT_W-1:0]  rx_slot;
    logic               peer_more_data;
    logic               rx_pending;
    logic [COUNT_W-1:0] crc_errors;
    status_t            status;
  } out_word_t;

endpackage

/* src/lafc_ctrl.sv */
module lafc_ctrl #(
  parameter int RING_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  lafc_pkg::in_word_t  in_word,
  output lafc_pkg::out_word_t out_word
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam logic [PW-1:0] LAST = PW'(RING_DEPTH - 1);

  logic [PW-1:0] rx_write_ptr, rx_write_ptr_next;
  logic [PW-1:0] rx_read_ptr, rx_read_ptr_next;
  logic [PW-1:0] tx_write_ptr, tx_write_ptr_next;
  logic [PW-1:0] tx_read_ptr, tx_read_ptr_next;
  logic expect_bit, expect_bit_next;
  logic own_seq_bit, own_seq_bit_next;
  logic tx_pending, tx_pending_next;
  logic peer_md_flag, peer_md_flag_next;
  logic [lafc_pkg::COUNT_W-1:0] crc_error_count, crc_error_count_next;
  logic accepted;
  logic [PW-1:0] slot;
  lafc_pkg::status_t status;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == LAST) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    rx_write_ptr_next    = rx_write_ptr;
    rx_read_ptr_next     = rx_read_ptr;
    tx_write_ptr_next    = tx_write_ptr;
    tx_read_ptr_next     = tx_read_ptr;
    expect_bit_next      = expect_bit;
    own_seq_bit_next     = own_seq_bit;
    tx_pending_next      = tx_pending;
    peer_md_flag_next    = peer_md_flag;
    crc_error_count_next = crc_error_count;
    accepted             = 1'b0;
    slot                 = '0;
    status               = lafc_pkg::STATUS_OK;
    unique case (in_word.command)
      lafc_pkg::CMD_RX_PACKET: begin
        if (!in_word.crc_ok) begin
          crc_error_count_next = crc_error_count + lafc_pkg::COUNT_W'(1);
          status               = lafc_pkg::STATUS_CRC_ERROR;
        end else begin
          peer_md_flag_next = in_word.hdr_md;
          if (in_word.hdr_sn == expect_bit) begin
            if (ring_next(rx_write_ptr) == rx_read_ptr) begin
              status = lafc_pkg::STATUS_RX_FULL;
            end else begin
              accepted          = 1'b1;
              slot              = rx_write_ptr;
              rx_write_ptr_next = ring_next(rx_write_ptr);
              expect_bit_next   = ~expect_bit;
            end
          end
          // peer acked our last packet: move on, or repeat an empty one
          if (in_word.hdr_nesn != own_seq_bit) begin
            if (tx_pending) begin
              tx_read_ptr_next = ring_next(tx_read_ptr);
            end
            if (tx_read_ptr_next == tx_write_ptr) begin
              tx_pending_next = 1'b0;
            end else begin
              tx_pending_next  = 1'b1;
              own_seq_bit_next = ~own_seq_bit;
            end
          end
        end
      end
      lafc_pkg::CMD_RX_RELEASE: begin
        if (rx_read_ptr == rx_write_ptr) begin
          status = lafc_pkg::STATUS_RX_EMPTY;
        end else begin
          rx_read_ptr_next = ring_next(rx_read_ptr);
        end
      end
      lafc_pkg::CMD_TX_QUEUE: begin
        if (ring_next(tx_write_ptr) == tx_read_ptr) begin
          status = lafc_pkg::STATUS_TX_FULL;
        end else begin
          tx_write_ptr_next = ring_next(tx_write_ptr);
        end
      end
      lafc_pkg::CMD_RESET: begin
        rx_write_ptr_next    = '0;
        rx_read_ptr_next     = '0;
        tx_write_ptr_next    = '0;
        tx_read_ptr_next     = '0;
        expect_bit_next      = 1'b0;
        own_seq_bit_next     = 1'b0;
        tx_pending_next      = 1'b0;
        peer_md_flag_next    = 1'b0;
        crc_error_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_word.tx_slot        = lafc_pkg::SLOT_W'(tx_read_ptr_next);
    out_word.tx_nesn        = expect_bit_next;
    out_word.tx_sn          = own_seq_bit_next;
    out_word.tx_md          = tx_pending_next;
    out_word.rx_accepted    = accepted;
    out_word.rx_slot        = lafc_pkg::SLOT_W'(slot);
    out_word.peer_more_data = peer_md_flag_next;
    out_word.rx_pending     = (rx_read_ptr_next != rx_write_ptr_next);
    out_word.crc_errors     = crc_error_count_next;
    out_word.status         = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_write_ptr    <= '0;
      rx_read_ptr     <= '0;
      tx_write_ptr    <= '0;
      tx_read_ptr     <= '0;
      expect_bit      <= 1'b0;
      own_seq_bit     <= 1'b0;
      tx_pending      <= 1'b0;
      peer_md_flag    <= 1'b0;
      crc_error_count <= '0;
    end else if (fire) begin
      rx_write_ptr    <= rx_write_ptr_next;
      rx_read_ptr     <= rx_read_ptr_next;
      tx_write_ptr    <= tx_write_ptr_next;
      tx_read_ptr     <= tx_read_ptr_next;
      expect_bit      <= expect_bit_next;
      own_seq_bit     <= own_seq_bit_next;
      tx_pending      <= tx_pending_next;
      peer_md_flag    <= peer_md_flag_next;
      crc_error_count <= crc_error_count_next;
    end
  end

endmodule

/* src/lafc_skid.sv */
module lafc_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lafc_pkg::out_word_t push_word,
  output logic                has_room,
  output logic                word_valid,
  input  logic                pop,
  output lafc_pkg::out_word_t word
);

  lafc_pkg::out_word_t buffer [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign has_room   = (count != 2'd2);
  assign word_valid = (count != 2'd0);
  assign word       = buffer[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      buffer[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/link_ack_flow_control.sv */
// A result word is computed combinationally and registered in the result buffer
// when its command is accepted. Throughput: one command word per cycle while the
// two-word result buffer has room, so in_ready stays high while one result waits.
// Reset (rst, synchronous): pointers, sequence bits, flags and the CRC error
//   count go to zero and the result buffer empties. The reset command does the same
//   to the link state only.
module link_ack_flow_control #(
  parameter int RING_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  // command channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic       crc_ok,
  input  logic       hdr_sn,
  input  logic       hdr_nesn,
  input  logic       hdr_md,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] tx_slot,
  output logic       tx_nesn,
  output logic       tx_sn,
  output logic       tx_md,
  output logic       rx_accepted,
  output logic [2:0] rx_slot,
  output logic       peer_more_data,
  output logic       rx_pending,
  output logic [7:0] crc_errors,
  output logic [2:0] status
);

  lafc_pkg::in_word_t  in_word;
  lafc_pkg::out_word_t step_word;
  lafc_pkg::out_word_t held_word;
  logic fire;
  logic pop;

  // every 2-bit command code is a legal command
  assign in_word.command  = lafc_pkg::command_t'(command);
  assign in_word.crc_ok   = crc_ok;
  assign in_word.hdr_sn   = hdr_sn;
  assign in_word.hdr_nesn = hdr_nesn;
  assign in_word.hdr_md   = hdr_md;

  assign fire = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  // link state and the next-header decision
  lafc_ctrl #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .in_word (in_word),
    .out_word(step_word)
  );

  // result registers; the second entry absorbs a stalled consumer
  lafc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_word (step_word),
    .has_room  (in_ready),
    .word_valid(out_valid),
    .pop       (pop),
    .word      (held_word)
  );

  assign tx_slot        = held_word.tx_slot;
  assign tx_nesn        = held_word.tx_nesn;
  assign tx_sn          = held_word.tx_sn;
  assign tx_md          = held_word.tx_md;
  assign rx_accepted    = held_word.rx_accepted;
  assign rx_slot        = held_word.rx_slot;
  assign peer_more_data = held_word.peer_more_data;
  assign rx_pending     = held_word.rx_pending;
  assign crc_errors     = held_word.crc_errors;
  assign status         = held_word.status;

  // a full buffer always has a word on offer
  a_full_has_word: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("buffer full but no result offered");

  // an accepted command always leaves a result behind
  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted command left no result");

  // a rejected packet reports slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rx_accepted) |-> (rx_slot == 3'd0))
    else $error("rx_slot nonzero without acceptance");

  // a CRC failure never delivers new data
  a_crc_no_accept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == lafc_pkg::STATUS_CRC_ERROR) |-> !rx_accepted)
    else $error("packet accepted on CRC error");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

// Checks link_ack_flow_control against an in-bench model of the SN/NESN
// acknowledgement scheme. A directed table comes first, then a burst of bad-CRC
// packets that wraps the error counter, then random words that mostly follow a
// well-behaved peer. Both channels idle at random, and the result side holds
// off once for a long stretch so that the result buffer fills.
module tb;

  localparam int RING_SLOTS   = 8;
  localparam int RANDOM_WORDS = 867;
  localparam int CRC_BURST    = 260;   // enough to wrap the 8-bit count
  localparam int RUN_LIMIT    = 100000;
  localparam int HOLD_AT      = 400;   // result side stops taking words here
  localparam int HOLD_LEN     = 80;
  localparam int CALM_FROM    = 1200;  // no idling on either side in this window
  localparam int CALM_TO      = 1700;
  localparam int DRAIN_CYCLES = 8;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] command = lafc_pkg::CMD_RX_PACKET;
  logic       crc_ok = 1'b0;
  logic       hdr_sn = 1'b0;
  logic       hdr_nesn = 1'b0;
  logic       hdr_md = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] tx_slot;
  logic       tx_nesn;
  logic       tx_sn;
  logic       tx_md;
  logic       rx_accepted;
  logic [2:0] rx_slot;
  logic       peer_more_data;
  logic       rx_pending;
  logic [7:0] crc_errors;
  logic [2:0] status;

  link_ack_flow_control #(.RING_DEPTH(RING_SLOTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .crc_ok(crc_ok), .hdr_sn(hdr_sn),
    .hdr_nesn(hdr_nesn), .hdr_md(hdr_md),
    .out_valid(out_valid), .out_ready(out_ready),
    .tx_slot(tx_slot), .tx_nesn(tx_nesn), .tx_sn(tx_sn), .tx_md(tx_md),
    .rx_accepted(rx_accepted), .rx_slot(rx_slot),
    .peer_more_data(peer_more_data), .rx_pending(rx_pending),
    .crc_errors(crc_errors), .status(status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Link model: ring pointers, sequence bits and flags as the bench sees them.
  // ---------------------------------------------------------------------------
  logic [lafc_pkg::SLOT_W-1:0]  rx_wr = '0, rx_rd = '0, tx_wr = '0, tx_rd = '0;
  logic                         nesn_expect = 1'b0;  // SN we want next from the peer
  logic                         seq_own = 1'b0;      // SN we send
  logic                         tx_busy = 1'b0;      // a data packet is in flight
  logic                         peer_md = 1'b0;
  logic [lafc_pkg::COUNT_W-1:0] crc_cnt = '0;

  lafc_pkg::out_word_t ack_expect_q[$];   // result words still owed by the block
  bit                  broke = 1'b0;
  int                  cycle_count = 0;

  function automatic logic [lafc_pkg::SLOT_W-1:0] slot_after(
      input logic [lafc_pkg::SLOT_W-1:0] p);
    return (p == lafc_pkg::SLOT_W'(RING_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  // Applies one command word to the link model and returns the result word.
  function automatic lafc_pkg::out_word_t link_predict(input lafc_pkg::in_word_t w);
    lafc_pkg::out_word_t r;
    r = '0;
    r.status = lafc_pkg::STATUS_OK;
    case (w.command)
      lafc_pkg::CMD_RX_PACKET: begin
        if (!w.crc_ok) begin
          // bad CRC: only the counter moves, flags are resent as they stand
          crc_cnt  = crc_cnt + 1'b1;
          r.status = lafc_pkg::STATUS_CRC_ERROR;
        end else begin
          peer_md = w.hdr_md;
          if (w.hdr_sn == nesn_expect) begin
            if (slot_after(rx_wr) == rx_rd) begin
              r.status = lafc_pkg::STATUS_RX_FULL;   // NESN held so the peer resends
            end else begin
              r.rx_accepted = 1'b1;
              r.rx_slot     = rx_wr;
              rx_wr         = slot_after(rx_wr);
              nesn_expect   = ~nesn_expect;
            end
          end
          // peer acked our last packet: move on, or repeat an empty one
          if (w.hdr_nesn != seq_own) begin
            if (tx_busy) tx_rd = slot_after(tx_rd);
            if (tx_rd == tx_wr) begin
              tx_busy = 1'b0;
            end else begin
              tx_busy = 1'b1;
              seq_own = ~seq_own;
            end
          end
        end
      end
      lafc_pkg::CMD_RX_RELEASE: begin
        if (rx_rd == rx_wr) r.status = lafc_pkg::STATUS_RX_EMPTY;
        else rx_rd = slot_after(rx_rd);
      end
      lafc_pkg::CMD_TX_QUEUE: begin
        if (slot_after(tx_wr) == tx_rd) r.status = lafc_pkg::STATUS_TX_FULL;
        else tx_wr = slot_after(tx_wr);
      end
      default: begin
        rx_wr = '0; rx_rd = '0; tx_wr = '0; tx_rd = '0;
        nesn_expect = 1'b0; seq_own = 1'b0; tx_busy = 1'b0;
        peer_md = 1'b0; crc_cnt = '0;
      end
    endcase
    r.tx_slot        = tx_rd;
    r.tx_nesn        = nesn_expect;
    r.tx_sn          = seq_own;
    r.tx_md          = tx_busy;
    r.peer_more_data = peer_md;
    r.rx_pending     = (rx_rd != rx_wr);
    r.crc_errors     = crc_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed words. Rows with typed set carry the result word written out by
  // hand; the rest are checked against the link model.
  // ---------------------------------------------------------------------------
  typedef struct {
    lafc_pkg::in_word_t  word;
    bit                  typed;
    lafc_pkg::out_word_t golden;
  } probe_t;

  localparam lafc_pkg::out_word_t FROM_MODEL = '0;

  probe_t probe_tab [0:22] = '{
    // release with nothing received
    '{'{lafc_pkg::CMD_RX_RELEASE, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{status: lafc_pkg::STATUS_RX_EMPTY, default: '0}},
    // bad CRC: header bits all set but must be ignored
    '{'{lafc_pkg::CMD_RX_PACKET, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{crc_errors: 8'd1, status: lafc_pkg::STATUS_CRC_ERROR, default: '0}},
    '{'{lafc_pkg::CMD_RX_PACKET, 1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, FROM_MODEL}, // new data
    '{'{lafc_pkg::CMD_RX_PACKET, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, FROM_MODEL}, // old, ack
    // fill the transmit ring, then one more
    '{'{lafc_pkg::CMD_TX_QUEUE, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, FROM_MODEL},
    '{'{lafc_pkg::CMD_TX_QUEUE, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, FROM_MODEL},
    '{'{lafc_pkg::CMD_TX_QUEUE, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, FROM_MODEL},
    '{'{lafc_pkg::CMD_TX_QUEUE, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, FROM_MODEL},
    '{'{lafc_pkg::CMD_TX_QUEUE, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, FROM_MODEL},
    '{'{lafc_pkg::CMD_TX_QUEUE, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, FROM_MODEL},
    '{'{lafc_pkg::CMD_TX_QUEUE, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, FROM_MODEL},
    '{'{lafc_pkg::CMD_TX_QUEUE, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, FROM_MODEL}, // ring full
    // in-sequence packets until the receive ring is full
    '{'{lafc_pkg::CMD_RX_PACKET, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, FROM_MODEL},
    '{'{lafc_pkg::CMD_RX_PACKET, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, FROM_MODEL},
    '{'{lafc_pkg::CMD_RX_PACKET, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, FROM_MODEL},
    '{'{lafc_pkg::CMD_RX_PACKET, 1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, FROM_MODEL},
    '{'{lafc_pkg::CMD_RX_PACKET, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, FROM_MODEL},
    '{'{lafc_pkg::CMD_RX_PACKET, 1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, FROM_MODEL},
    '{'{lafc_pkg::CMD_RX_PACKET, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, FROM_MODEL}, // rx full
    '{'{lafc_pkg::CMD_RX_RELEASE, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, FROM_MODEL},
    // reset command wipes the link state
    '{'{lafc_pkg::CMD_RESET, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{status: lafc_pkg::STATUS_OK, default: '0}},
    '{'{lafc_pkg::CMD_RX_RELEASE, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{status: lafc_pkg::STATUS_RX_EMPTY, default: '0}},
    '{'{lafc_pkg::CMD_RX_PACKET, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, FROM_MODEL}
  };

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------
  function automatic bit calm_now();
    return cycle_count >= CALM_FROM && cycle_count < CALM_TO;
  endfunction

  // Idle cycles at random, then hold the word until it is taken; log what it owes.
  task automatic issue_word(input lafc_pkg::in_word_t w, input bit typed,
                            input lafc_pkg::out_word_t golden);
    lafc_pkg::out_word_t predicted;
    while (!calm_now() && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= w.command;
    crc_ok   <= w.crc_ok;
    hdr_sn   <= w.hdr_sn;
    hdr_nesn <= w.hdr_nesn;
    hdr_md   <= w.hdr_md;
    do @(posedge clk); while (!in_ready);
    predicted = link_predict(w);
    ack_expect_q.push_back(typed ? golden : predicted);
  endtask

  // Mostly a well-behaved peer: right SN, acks our packets, good CRC.
  function automatic lafc_pkg::in_word_t peer_word();
    lafc_pkg::in_word_t w;
    int                 pick;
    pick       = $urandom_range(99);
    w.command  = (pick < 49) ? lafc_pkg::CMD_RX_PACKET :
                 (pick < 72) ? lafc_pkg::CMD_RX_RELEASE :
                 (pick < 99) ? lafc_pkg::CMD_TX_QUEUE : lafc_pkg::CMD_RESET;
    w.crc_ok   = ($urandom_range(9) != 0);
    w.hdr_sn   = ($urandom_range(4) != 0) ? nesn_expect : 1'($urandom);
    w.hdr_nesn = ($urandom_range(3) != 0) ? ~seq_own : 1'($urandom);
    w.hdr_md   = 1'($urandom);
    return w;
  endfunction

  initial begin : source
    lafc_pkg::in_word_t w;
    wait (!rst);
    @(posedge clk);
    foreach (probe_tab[i]) issue_word(probe_tab[i].word, probe_tab[i].typed,
                                      probe_tab[i].golden);
    // bad-CRC run long enough to wrap the counter; header bits random
    for (int n = 0; n < CRC_BURST; n++) begin
      w.command  = lafc_pkg::CMD_RX_PACKET;
      w.crc_ok   = 1'b0;
      w.hdr_sn   = 1'($urandom);
      w.hdr_nesn = 1'($urandom);
      w.hdr_md   = 1'($urandom);
      issue_word(w, 1'b0, FROM_MODEL);
    end
    for (int n = 0; n < RANDOM_WORDS; n++) issue_word(peer_word(), 1'b0, FROM_MODEL);
    in_valid <= 1'b0;

    while (ack_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!broke)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, one long hold-off, a calm window.
  // ---------------------------------------------------------------------------
  initial begin : sink
    int hold_left;
    hold_left = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (cycle_count == HOLD_AT) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm_now()) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 34);
      end
    end
  end

  // reset at the start, cycle count, run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == 9) rst <= 1'b0;
    if (cycle_count == RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void note_miss(input string field, input logic [7:0] want,
                                    input logic [7:0] seen);
    broke = 1'b1;
    $display("%0t: %s expected %0d got %0d", $time, field, want, seen);
  endfunction

  always @(posedge clk) begin : result_check
    lafc_pkg::out_word_t seen, want;
    if (!rst && out_valid && out_ready) begin
      seen = '{tx_slot, tx_nesn, tx_sn, tx_md, rx_accepted, rx_slot,
               peer_more_data, rx_pending, crc_errors, lafc_pkg::status_t'(status)};
      if (ack_expect_q.size() == 0) begin
        broke = 1'b1;
        $display("%0t: result word with none expected, got %h", $time, seen);
      end else begin
        want = ack_expect_q.pop_front();
        if (seen.tx_slot !== want.tx_slot)
          note_miss("tx_slot", want.tx_slot, seen.tx_slot);
        if (seen.tx_nesn !== want.tx_nesn)
          note_miss("tx_nesn", want.tx_nesn, seen.tx_nesn);
        if (seen.tx_sn !== want.tx_sn)
          note_miss("tx_sn", want.tx_sn, seen.tx_sn);
        if (seen.tx_md !== want.tx_md)
          note_miss("tx_md", want.tx_md, seen.tx_md);
        if (seen.rx_accepted !== want.rx_accepted)
          note_miss("rx_accepted", want.rx_accepted, seen.rx_accepted);
        if (seen.rx_slot !== want.rx_slot)
          note_miss("rx_slot", want.rx_slot, seen.rx_slot);
        if (seen.peer_more_data !== want.peer_more_data)
          note_miss("peer_more_data", want.peer_more_data, seen.peer_more_data);
        if (seen.rx_pending !== want.rx_pending)
          note_miss("rx_pending", want.rx_pending, seen.rx_pending);
        if (seen.crc_errors !== want.crc_errors)
          note_miss("crc_errors", want.crc_errors, seen.crc_errors);
        if (seen.status !== want.status)
          note_miss("status", want.status, seen.status);
      end
    end
  end

endmodule
